@@ rtl/clsnc_pkg.sv @@
// Shared types, constants and state codes for the cell-list shell neighbor counter.
`timescale 1ns / 1ps
package clsnc_pkg;

  localparam int COORD_BITS     = 20;
  localparam int GRID_BITS      = 5;
  localparam int GRID_CELLS     = 1 << GRID_BITS;
  localparam int PT_ADDR_BITS   = 16;
  localparam int MAX_POINTS     = 1 << PT_ADDR_BITS;
  localparam int CELL_ADDR_BITS = 3 * GRID_BITS;
  localparam int NUM_CELLS      = 1 << CELL_ADDR_BITS;
  localparam int COUNT_BITS     = 16;
  localparam int SQ_BITS        = 2 * COORD_BITS;
  localparam int D2_BITS        = SQ_BITS + 2;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LD_HEAD,
    ST_Q_CEN,
    ST_Q_CELL,
    ST_Q_HEAD,
    ST_Q_WALK,
    ST_Q_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [COORD_BITS-1:0] point_z;
    logic                  point_live;
    logic [15:0]           center_index;
    logic [COORD_BITS-1:0] radius_inner;
    logic [COORD_BITS-1:0] radius_outer;
  } in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] neighbor_count;
    logic                  table_full;
  } out_t;

  // One word of the point memory: chain link plus the point itself.
  typedef struct packed {
    logic                    link_valid;
    logic [PT_ADDR_BITS-1:0] link;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic [COORD_BITS-1:0]   z;
    logic                    live;
  } pt_word_t;

  typedef struct packed {
    logic                    valid;
    logic [PT_ADDR_BITS-1:0] idx;
  } head_t;

  // A candidate point handed to the distance pipeline.
  typedef struct packed {
    logic                  valid;
    logic                  live;
    logic                  self;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } cand_t;

  function automatic logic [GRID_BITS-1:0] axis_cell(input logic [COORD_BITS-1:0] c);
    return c[COORD_BITS-1 -: GRID_BITS];
  endfunction

endpackage

@@ rtl/clsnc_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module clsnc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/clsnc_dist.sv @@
// Distance pipeline: squares, shell compare and saturating neighbor count.
`timescale 1ns / 1ps
module clsnc_dist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  clsnc_pkg::cand_t                    cand_i,
  input  logic [clsnc_pkg::COORD_BITS-1:0]    cen_x_i,
  input  logic [clsnc_pkg::COORD_BITS-1:0]    cen_y_i,
  input  logic [clsnc_pkg::COORD_BITS-1:0]    cen_z_i,
  input  logic [clsnc_pkg::SQ_BITS-1:0]       rin2_i,
  input  logic [clsnc_pkg::SQ_BITS-1:0]       rout2_i,
  output logic [clsnc_pkg::COUNT_BITS-1:0]    count_o,
  output logic                                busy_o
);

  logic                            v1_q, ok1_q, hit2_q, v2_q;
  logic [clsnc_pkg::SQ_BITS-1:0]   sqx_q, sqy_q, sqz_q;
  logic [clsnc_pkg::COORD_BITS-1:0] dx, dy, dz;
  logic [clsnc_pkg::D2_BITS-1:0]   d2;
  logic                            hit2_d;
  logic [clsnc_pkg::COUNT_BITS-1:0] count_q;

  assign dx = (cand_i.x > cen_x_i) ? cand_i.x - cen_x_i : cen_x_i - cand_i.x;
  assign dy = (cand_i.y > cen_y_i) ? cand_i.y - cen_y_i : cen_y_i - cand_i.y;
  assign dz = (cand_i.z > cen_z_i) ? cand_i.z - cen_z_i : cen_z_i - cand_i.z;

  assign d2 = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
  assign hit2_d = v1_q && ok1_q && (d2 > {2'b00, rin2_i}) && (d2 < {2'b00, rout2_i});

  always_ff @(posedge clk_i) begin
    sqx_q <= {{clsnc_pkg::COORD_BITS{1'b0}}, dx} * {{clsnc_pkg::COORD_BITS{1'b0}}, dx};
    sqy_q <= {{clsnc_pkg::COORD_BITS{1'b0}}, dy} * {{clsnc_pkg::COORD_BITS{1'b0}}, dy};
    sqz_q <= {{clsnc_pkg::COORD_BITS{1'b0}}, dz} * {{clsnc_pkg::COORD_BITS{1'b0}}, dz};
    ok1_q <= cand_i.live && !cand_i.self;
    hit2_q <= hit2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      count_q <= '0;
    end else begin
      v1_q <= cand_i.valid;
      v2_q <= v1_q;
      if (clear_i) begin
        count_q <= '0;
      end else if (v2_q && hit2_q && (count_q != '1)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign count_o = count_q;
  assign busy_o  = v1_q || v2_q;

endmodule

@@ rtl/cell_list_shell_neighbor_count.sv @@
// Top level: cell-linked list of points with a shell neighbor count query.
`timescale 1ns / 1ps
// An item transfers when start_i is high and busy_o is low; any result shows on
// result_o for one cycle with done_o high and must be taken then. A load reads
// the cell head and then writes point, link and head; when the store is full it
// only answers with table_full set. A query reads the center, then for each cell
// of the clamped bounding cube reads the cell head and walks its chain of points,
// one point at a time through the single point memory port, and last drains the
// distance pipeline. A clear empties all 32768 cell heads one per cycle, and the
// same pass runs after reset, with busy_o high throughout. Clear and an unused mode give no result.
module cell_list_shell_neighbor_count (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  clsnc_pkg::in_t     in_i,
  output logic               busy_o,
  output logic               done_o,
  output clsnc_pkg::out_t    result_o
);

  clsnc_pkg::state_e state_q, state_d;
  logic [clsnc_pkg::PT_ADDR_BITS:0]     count_q, count_d;
  logic [clsnc_pkg::CELL_ADDR_BITS-1:0] clr_q, clr_d;
  clsnc_pkg::in_t  in_q, in_d;
  logic [clsnc_pkg::COORD_BITS-1:0] cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  logic [clsnc_pkg::SQ_BITS-1:0]    rin2_q, rout2_q;
  logic [clsnc_pkg::GRID_BITS-1:0]  lox_q, loy_q, loz_q, hix_q, hiy_q, hiz_q;
  logic [clsnc_pkg::GRID_BITS-1:0]  lox_d, loy_d, loz_d, hix_d, hiy_d, hiz_d;
  logic [clsnc_pkg::GRID_BITS-1:0]  i_q, j_q, k_q, i_d, j_d, k_d;
  logic [clsnc_pkg::GRID_BITS-1:0]  ni, nj, nk;
  logic [clsnc_pkg::PT_ADDR_BITS-1:0] cur_q, cur_d;
  logic            done_q, done_d;
  clsnc_pkg::out_t res_q, res_d;
  logic            last_cell;

  logic                                  pt_we, hd_we, dist_clear, dist_busy;
  logic [clsnc_pkg::PT_ADDR_BITS-1:0]    pt_addr;
  logic [clsnc_pkg::CELL_ADDR_BITS-1:0]  hd_addr;
  clsnc_pkg::pt_word_t                   pt_wdata, pt_rdata;
  clsnc_pkg::head_t                      hd_wdata, hd_rdata;
  clsnc_pkg::cand_t                      cand;
  logic [clsnc_pkg::COUNT_BITS-1:0]      dist_count;
  logic [clsnc_pkg::COORD_BITS:0]        sx, sy, sz;

  clsnc_ram #(.Width($bits(clsnc_pkg::pt_word_t)), .Depth(clsnc_pkg::MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .addr_i  (pt_addr),
    .wdata_i (pt_wdata),
    .rdata_o (pt_rdata)
  );

  clsnc_ram #(.Width($bits(clsnc_pkg::head_t)), .Depth(clsnc_pkg::NUM_CELLS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (hd_we),
    .addr_i  (hd_addr),
    .wdata_i (hd_wdata),
    .rdata_o (hd_rdata)
  );

  clsnc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (dist_clear),
    .cand_i  (cand),
    .cen_x_i (cx_q),
    .cen_y_i (cy_q),
    .cen_z_i (cz_q),
    .rin2_i  (rin2_q),
    .rout2_i (rout2_q),
    .count_o (dist_count),
    .busy_o  (dist_busy)
  );

  // Bounding cube of the center, clamped to the grid, from the center read.
  assign sx = {1'b0, pt_rdata.x} + {1'b0, in_q.radius_outer};
  assign sy = {1'b0, pt_rdata.y} + {1'b0, in_q.radius_outer};
  assign sz = {1'b0, pt_rdata.z} + {1'b0, in_q.radius_outer};
  assign lox_d = (pt_rdata.x < in_q.radius_outer) ? '0 :
                 clsnc_pkg::axis_cell(pt_rdata.x - in_q.radius_outer);
  assign loy_d = (pt_rdata.y < in_q.radius_outer) ? '0 :
                 clsnc_pkg::axis_cell(pt_rdata.y - in_q.radius_outer);
  assign loz_d = (pt_rdata.z < in_q.radius_outer) ? '0 :
                 clsnc_pkg::axis_cell(pt_rdata.z - in_q.radius_outer);
  assign hix_d = sx[clsnc_pkg::COORD_BITS] ? '1 : clsnc_pkg::axis_cell(sx[clsnc_pkg::COORD_BITS-1:0]);
  assign hiy_d = sy[clsnc_pkg::COORD_BITS] ? '1 : clsnc_pkg::axis_cell(sy[clsnc_pkg::COORD_BITS-1:0]);
  assign hiz_d = sz[clsnc_pkg::COORD_BITS] ? '1 : clsnc_pkg::axis_cell(sz[clsnc_pkg::COORD_BITS-1:0]);

  // Cell walk order: z fastest, then y, then x.
  assign last_cell = (i_q == hix_q) && (j_q == hiy_q) && (k_q == hiz_q);
  always_comb begin
    ni = i_q;
    nj = j_q;
    nk = k_q;
    if (k_q != hiz_q) begin
      nk = k_q + 1'b1;
    end else begin
      nk = loz_q;
      if (j_q != hiy_q) begin
        nj = j_q + 1'b1;
      end else begin
        nj = loy_q;
        ni = i_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    clr_d      = clr_q;
    in_d       = in_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    cz_d       = cz_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    cur_d      = cur_q;
    done_d     = 1'b0;
    res_d      = res_q;
    pt_we      = 1'b0;
    pt_addr    = cur_q;
    pt_wdata   = '0;
    hd_we      = 1'b0;
    hd_addr    = {i_q, j_q, k_q};
    hd_wdata   = '0;
    cand       = '0;
    dist_clear = 1'b0;

    unique case (state_q)
      clsnc_pkg::ST_IDLE: begin
        if (start_i) begin
          in_d = in_i;
          unique case (clsnc_pkg::mode_e'(in_i.mode))
            clsnc_pkg::MODE_LOAD: begin
              if (count_q[clsnc_pkg::PT_ADDR_BITS]) begin
                done_d = 1'b1;
                res_d  = '{neighbor_count: '0, table_full: 1'b1};
              end else begin
                hd_addr = {clsnc_pkg::axis_cell(in_i.point_x),
                           clsnc_pkg::axis_cell(in_i.point_y),
                           clsnc_pkg::axis_cell(in_i.point_z)};
                state_d = clsnc_pkg::ST_LD_HEAD;
              end
            end
            clsnc_pkg::MODE_QUERY: begin
              pt_addr    = in_i.center_index;
              dist_clear = 1'b1;
              state_d    = clsnc_pkg::ST_Q_CEN;
            end
            clsnc_pkg::MODE_CLEAR: begin
              clr_d   = '0;
              state_d = clsnc_pkg::ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      clsnc_pkg::ST_CLEAR: begin
        hd_we   = 1'b1;
        hd_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = clsnc_pkg::ST_IDLE;
        end
      end

      clsnc_pkg::ST_LD_HEAD: begin
        pt_we    = 1'b1;
        pt_addr  = count_q[clsnc_pkg::PT_ADDR_BITS-1:0];
        pt_wdata = '{link_valid: hd_rdata.valid, link: hd_rdata.idx, x: in_q.point_x,
                     y: in_q.point_y, z: in_q.point_z, live: in_q.point_live};
        hd_we    = 1'b1;
        hd_addr  = {clsnc_pkg::axis_cell(in_q.point_x),
                    clsnc_pkg::axis_cell(in_q.point_y),
                    clsnc_pkg::axis_cell(in_q.point_z)};
        hd_wdata = '{valid: 1'b1, idx: count_q[clsnc_pkg::PT_ADDR_BITS-1:0]};
        count_d  = count_q + 1'b1;
        done_d   = 1'b1;
        res_d    = '{neighbor_count: '0, table_full: 1'b0};
        state_d  = clsnc_pkg::ST_IDLE;
      end

      clsnc_pkg::ST_Q_CEN: begin
        // A center that was never stored, or that is not live, answers zero.
        if (({1'b0, in_q.center_index} >= count_q) || !pt_rdata.live) begin
          done_d  = 1'b1;
          res_d   = '{neighbor_count: '0, table_full: 1'b0};
          state_d = clsnc_pkg::ST_IDLE;
        end else begin
          cx_d    = pt_rdata.x;
          cy_d    = pt_rdata.y;
          cz_d    = pt_rdata.z;
          i_d     = lox_d;
          j_d     = loy_d;
          k_d     = loz_d;
          state_d = clsnc_pkg::ST_Q_CELL;
        end
      end

      clsnc_pkg::ST_Q_CELL: begin
        state_d = clsnc_pkg::ST_Q_HEAD;
      end

      clsnc_pkg::ST_Q_HEAD: begin
        if (hd_rdata.valid) begin
          pt_addr = hd_rdata.idx;
          cur_d   = hd_rdata.idx;
          state_d = clsnc_pkg::ST_Q_WALK;
        end else if (last_cell) begin
          state_d = clsnc_pkg::ST_Q_DRAIN;
        end else begin
          i_d     = ni;
          j_d     = nj;
          k_d     = nk;
          state_d = clsnc_pkg::ST_Q_CELL;
        end
      end

      clsnc_pkg::ST_Q_WALK: begin
        cand = '{valid: 1'b1, live: pt_rdata.live, self: (cur_q == in_q.center_index),
                 x: pt_rdata.x, y: pt_rdata.y, z: pt_rdata.z};
        if (pt_rdata.link_valid) begin
          pt_addr = pt_rdata.link;
          cur_d   = pt_rdata.link;
        end else if (last_cell) begin
          state_d = clsnc_pkg::ST_Q_DRAIN;
        end else begin
          i_d     = ni;
          j_d     = nj;
          k_d     = nk;
          state_d = clsnc_pkg::ST_Q_CELL;
        end
      end

      clsnc_pkg::ST_Q_DRAIN: begin
        if (!dist_busy) begin
          done_d  = 1'b1;
          res_d   = '{neighbor_count: dist_count, table_full: 1'b0};
          state_d = clsnc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = clsnc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clsnc_pkg::ST_CLEAR;
      count_q <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    cz_q  <= cz_d;
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
    cur_q <= cur_d;
    res_q <= res_d;
    if (state_q == clsnc_pkg::ST_Q_CEN) begin
      lox_q   <= lox_d;
      loy_q   <= loy_d;
      loz_q   <= loz_d;
      hix_q   <= hix_d;
      hiy_q   <= hiy_d;
      hiz_q   <= hiz_d;
      rin2_q  <= {{clsnc_pkg::COORD_BITS{1'b0}}, in_q.radius_inner} *
                 {{clsnc_pkg::COORD_BITS{1'b0}}, in_q.radius_inner};
      rout2_q <= {{clsnc_pkg::COORD_BITS{1'b0}}, in_q.radius_outer} *
                 {{clsnc_pkg::COORD_BITS{1'b0}}, in_q.radius_outer};
    end
  end

  assign busy_o   = (state_q != clsnc_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
